// File: rtl/tms_pkg.sv
package tms_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register select: paddr[2] picks the register, low bits are byte offset
  localparam logic REG_TENURE    = 1'b0;
  localparam logic REG_INIT_BEST = 1'b1;

  localparam logic [4:0]         TENURE_RESET    = 5'd15;
  localparam logic signed [31:0] INIT_BEST_RESET = 32'sh7FFF_FFFF;

  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_ASPIRED  = 2'd1;
  localparam logic [1:0] KIND_FALLBACK = 2'd2;

  typedef struct packed {
    logic [31:0]        move_key;
    logic signed [31:0] move_delta;
    logic signed [31:0] current_objective;
    logic               last_move;
  } tms_item_t;

  typedef struct packed {
    logic [31:0]        chosen_key;
    logic [15:0]        chosen_index;
    logic signed [31:0] chosen_delta;
    logic [1:0]         selection_kind;
    logic signed [31:0] new_best_objective;
  } tms_result_t;

  // queued candidate, with the aspiration sum precomputed by the front
  typedef struct packed {
    logic [31:0]        move_key;
    logic signed [31:0] move_delta;
    logic signed [31:0] current_objective;
    logic               last_move;
    logic signed [32:0] asp_sum;
  } tms_qitem_t;

  typedef struct packed {
    logic [4:0]         tenure;
    logic               best_load;
    logic signed [31:0] best_value;
  } tms_cfg_t;

endpackage

// File: rtl/tabu_move_selector_core.sv
// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   tms_item_t   (one candidate move)
// result    out        result_valid/result_stall tms_result_t (one per round)
// apb       in/out     psel/penable/pwrite     tenure @0x0, initial best @0x4
//
// Back end: a candidate is checked against all count entries of the tabu list,
// where count is the list fill; the list is scanned one entry a cycle through
// a single read port, then the candidate is judged. A round-closing item adds
// the list update, an optional fallback read of the oldest entry and the result
// load, plus any wait for a result still held in the output register.
// Reset: synchronous, clears list pointers, round state and valids; best
// objective returns to the register reset value. List memory is not cleared.
// Stalls: a two-beat queue takes candidates, until both slots are full, while the
// back end scans or a result waits; the result register holds its beat until taken.
module tabu_move_selector_core #(
  parameter int TABU_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  tms_pkg::tms_item_t           item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output tms_pkg::tms_result_t         result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tms_pkg::PADDR_W-1:0]  paddr,
  input  logic [tms_pkg::PDATA_W-1:0]  pwdata,
  output logic [tms_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tms_pkg::*;

  tms_cfg_t   cfg;
  logic       q_valid;
  tms_qitem_t q_data;
  logic       q_pop;

  // register file; a write of the initial best also reloads the running best
  tms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: takes candidate beats, forms current+delta for the aspiration test
  tms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // back: tabu scan, round selection, list update and result register
  tms_back #(
    .TABU_DEPTH (TABU_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/tms_cfg.sv
module tms_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tms_pkg::PADDR_W-1:0]   paddr,
  input  logic [tms_pkg::PDATA_W-1:0]   pwdata,
  output logic [tms_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tms_pkg::tms_cfg_t             cfg
);
  import tms_pkg::*;

  logic [4:0]         tenure;
  logic signed [31:0] init_best;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tenure    <= TENURE_RESET;
      init_best <= INIT_BEST_RESET;
    end else if (wr) begin
      if (paddr[2] == REG_INIT_BEST) begin
        init_best <= pwdata;
      end else begin
        tenure <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TENURE:    prdata = {27'd0, tenure};
      REG_INIT_BEST: prdata = init_best;
      default:       prdata = '0;
    endcase
  end

  assign cfg.tenure     = tenure;
  assign cfg.best_load  = wr && (paddr[2] == REG_INIT_BEST);
  assign cfg.best_value = pwdata;

endmodule

// File: rtl/tms_front.sv
module tms_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  tms_pkg::tms_item_t   item,
  output logic                 q_valid,
  output tms_pkg::tms_qitem_t  q_data,
  input  logic                 q_pop
);
  import tms_pkg::*;

  // two-slot queue
  tms_qitem_t slots [2];
  tms_qitem_t cls;
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  assign item_stall = fill[1];
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != 2'd0);
  assign q_data     = slots[rd_ptr];

  always_comb begin
    cls.move_key          = item.move_key;
    cls.move_delta        = item.move_delta;
    cls.current_objective = item.current_objective;
    cls.last_move         = item.last_move;
    cls.asp_sum           = {item.current_objective[31], item.current_objective}
                          + {item.move_delta[31], item.move_delta};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
  end

endmodule

// File: rtl/tms_back.sv
module tms_back #(
  parameter int TABU_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tms_pkg::tms_cfg_t    cfg,
  input  logic                 q_valid,
  input  tms_pkg::tms_qitem_t  q_data,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output tms_pkg::tms_result_t result
);
  import tms_pkg::*;

  localparam int AW = $clog2(TABU_DEPTH);
  localparam int CW = $clog2(TABU_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_FINISH = 6'b001000,
    S_FBRD   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(ofs);
    if (s >= (AW+1)'(TABU_DEPTH)) s = s - (AW+1)'(TABU_DEPTH);
    return s[AW-1:0];
  endfunction

  state_t             state;
  tms_qitem_t         cur_item;

  // tabu list: circular buffer in a 1R1W memory
  logic [31:0]        mem [TABU_DEPTH];
  logic [31:0]        rdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      head;
  logic [AW-1:0]      head_inc;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_idx;
  logic [CW-1:0]      limit;
  logic               scan_more;
  logic               rd_vld;
  logic               hit;
  logic               evict;

  // round state
  logic signed [31:0] best;
  logic signed [32:0] best_ext;
  logic signed [31:0] rb_delta;
  logic [31:0]        rb_key;
  logic [15:0]        rb_index;
  logic [15:0]        item_cnt;
  logic               found;
  logic               asp;
  logic               aspires;
  logic               better;
  logic signed [32:0] sum33;
  logic               improve;
  logic signed [31:0] best_upd;

  tms_result_t        res;
  tms_result_t        out_data;
  logic               out_valid;

  assign result_valid = out_valid;
  assign result       = out_data;

  // tenure 0 acts as 1, above depth acts as depth
  always_comb begin
    if (cfg.tenure == 5'd0) begin
      limit = CW'(1);
    end else if (32'(cfg.tenure) > 32'(TABU_DEPTH)) begin
      limit = CW'(TABU_DEPTH);
    end else begin
      limit = CW'(cfg.tenure);
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign scan_more = (scan_idx < count);
  assign head_inc  = (head == AW'(TABU_DEPTH - 1)) ? '0 : head + AW'(1);
  assign evict     = (count >= limit) && (count != '0);

  assign rd_en   = ((state == S_SCAN) && scan_more)
                || ((state == S_FINISH) && !found && (count != '0));
  assign rd_addr = (state == S_SCAN) ? wrap_addr(head, scan_idx) : head;
  assign we      = (state == S_FINISH) && found && !asp;
  // slot after the newest entry; unchanged by an eviction in the same cycle
  assign waddr   = wrap_addr(head, count);

  assign best_ext = {best[31], best};
  assign aspires  = hit && (cur_item.asp_sum < best_ext);
  assign better   = !found || (cur_item.move_delta < rb_delta);
  assign sum33    = {cur_item.current_objective[31], cur_item.current_objective}
                  + {rb_delta[31], rb_delta};
  assign improve  = (sum33 < best_ext);
  assign best_upd = (sum33[32] && !sum33[31]) ? 32'sh8000_0000 : sum33[31:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= rb_key;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
      best      <= INIT_BEST_RESET;
      rb_delta  <= '0;
      rb_key    <= '0;
      rb_index  <= '0;
      item_cnt  <= '0;
      found     <= 1'b0;
      asp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            hit      <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare lags the read issue, using the registered read data in the next cycle
          if (rd_vld && (rdata == cur_item.move_key)) hit <= 1'b1;
          rd_vld <= scan_more;
          if (scan_more) begin
            scan_idx <= scan_idx + CW'(1);
          end else if (!rd_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          item_cnt <= item_cnt + 16'd1;
          if ((!hit || aspires) && better) begin
            found    <= 1'b1;
            asp      <= aspires;
            rb_delta <= cur_item.move_delta;
            rb_key   <= cur_item.move_key;
            rb_index <= item_cnt;
          end
          state <= cur_item.last_move ? S_FINISH : S_IDLE;
        end
        S_FINISH: begin
          if (found) begin
            if (!asp) begin
              if (evict) begin
                head <= head_inc;
              end else begin
                count <= count + CW'(1);
              end
            end
            state <= S_EMIT;
          end else if (count != '0) begin
            head  <= head_inc;
            count <= count - CW'(1);
            state <= S_FBRD;
          end else begin
            state <= S_EMIT;
          end
          found    <= 1'b0;
          asp      <= 1'b0;
          rb_delta <= '0;
          rb_key   <= '0;
          rb_index <= '0;
          item_cnt <= '0;
        end
        S_FBRD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if ((state == S_EMIT) && (!out_valid || !result_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !result_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg.best_load) begin
        best <= cfg.best_value;
      end else if ((state == S_FINISH) && found && improve) begin
        best <= best_upd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_item <= q_data;
    if (state == S_FINISH) begin
      if (found) begin
        res.chosen_key     <= rb_key;
        res.chosen_index   <= rb_index;
        res.chosen_delta   <= rb_delta;
        res.selection_kind <= asp ? KIND_ASPIRED : KIND_NORMAL;
      end else begin
        res.chosen_key     <= '0;
        res.chosen_index   <= '0;
        res.chosen_delta   <= '0;
        res.selection_kind <= KIND_FALLBACK;
      end
      // best as it stands once this round's update lands
      res.new_best_objective <= (found && improve) ? best_upd : best;
    end
    if (state == S_FBRD) res.chosen_key <= rdata;
    if ((state == S_EMIT) && (!out_valid || !result_stall)) out_data <= res;
  end

endmodule

// File: tb/tabu_move_selector_core_test.sv
module tabu_move_selector_core_test;
  import tms_pkg::*;

  localparam int DEPTH         = 16;
  localparam int SETTLE_CYCLES = 40;    // lets the back end finish its worst-case round
  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 92;

  localparam longint OBJ_MIN = -64'sd2147483648;
  localparam longint OBJ_MAX = 64'sd2147483647;

  localparam logic [PADDR_W-1:0] ADDR_TENURE    = {REG_TENURE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_INIT_BEST = {REG_INIT_BEST, 2'b00};

  // idle modes: who is allowed to insert gaps
  localparam int IDLE_BOTH = 0;
  localparam int IDLE_NONE = 1;
  localparam int IDLE_SEND = 2;
  localparam int IDLE_RECV = 3;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  tms_item_t            item;
  logic                 result_valid;
  logic                 result_stall;
  tms_result_t          result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  tabu_move_selector_core #(.TABU_DEPTH(DEPTH)) u_dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow of the selector: tabu FIFO, best objective, per-round winner.
  // ---------------------------------------------------------------------------
  logic [31:0]        tl_mem [DEPTH];
  int                 tl_head;
  int                 tl_count;
  longint             best_obj;
  logic [4:0]         cfg_tenure;
  logic signed [31:0] cfg_init_best;

  longint             rnd_delta;
  logic [31:0]        rnd_key;
  logic [15:0]        rnd_index;
  bit                 rnd_found;
  bit                 rnd_asp;
  logic [15:0]        rnd_count;

  tms_result_t        pending_choices [$];  // expected round results, oldest first
  int                 mismatches;
  int                 idle_mode;
  logic [31:0]        key_pool [6];

  typedef struct {
    tms_item_t   beat;
    bit          typed;   // expected result written out below, not predicted
    tms_result_t want;
  } plan_row_t;

  function automatic plan_row_t plan_row(logic [31:0] key, logic [31:0] delta,
                                         logic [31:0] cur, bit last, bit typed,
                                         tms_result_t want);
    plan_row_t r;
    r.beat.move_key          = key;
    r.beat.move_delta        = delta;
    r.beat.current_objective = cur;
    r.beat.last_move         = last;
    r.typed                  = typed;
    r.want                   = want;
    return r;
  endfunction

  function automatic logic signed [31:0] clip_obj(longint v);
    longint c;
    c = v;
    if (c < OBJ_MIN) c = OBJ_MIN;
    if (c > OBJ_MAX) c = OBJ_MAX;
    return c[31:0];
  endfunction

  // tenure 0 behaves as 1, anything past the list depth as the depth
  function automatic int tenure_cap();
    if (cfg_tenure == 0) return 1;
    if (cfg_tenure > DEPTH) return DEPTH;
    return int'(cfg_tenure);
  endfunction

  function automatic bit key_in_list(logic [31:0] k);
    for (int i = 0; i < tl_count; i++)
      if (tl_mem[(tl_head + i) % DEPTH] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_round();
    rnd_delta = 0;
    rnd_key   = '0;
    rnd_index = '0;
    rnd_found = 1'b0;
    rnd_asp   = 1'b0;
    rnd_count = '0;
  endfunction

  // One candidate in; on the closing candidate, the round's choice out.
  task automatic select_move(input tms_item_t beat, output bit closed,
                             output tms_result_t res);
    longint      delta;
    longint      cur;
    longint      sum;
    bit          tabu;
    bit          aspires;
    logic [15:0] pos;
    delta   = longint'($signed(beat.move_delta));
    cur     = longint'($signed(beat.current_objective));
    tabu    = key_in_list(beat.move_key);
    // aspiration sees best as it stood at round start
    aspires = tabu && (cur + delta < best_obj);
    pos     = rnd_count;
    rnd_count = rnd_count + 16'd1;
    if (!tabu || aspires) begin
      // strict compare: first candidate wins a tie
      if (!rnd_found || delta < rnd_delta) begin
        rnd_found = 1'b1;
        rnd_asp   = aspires;
        rnd_delta = delta;
        rnd_key   = beat.move_key;
        rnd_index = pos;
      end
    end
    closed = beat.last_move;
    res    = '0;
    if (closed) begin
      if (rnd_found) begin
        sum                = cur + rnd_delta;
        res.chosen_key     = rnd_key;
        res.chosen_index   = rnd_index;
        res.chosen_delta   = rnd_delta[31:0];
        res.selection_kind = rnd_asp ? KIND_ASPIRED : KIND_NORMAL;
        if (!rnd_asp) begin
          // full list drops only its oldest entry, even if tenure shrank
          if (tl_count >= tenure_cap() && tl_count > 0) begin
            tl_head  = (tl_head + 1) % DEPTH;
            tl_count = tl_count - 1;
          end
          tl_mem[(tl_head + tl_count) % DEPTH] = rnd_key;
          tl_count = tl_count + 1;
        end
        if (sum < best_obj) best_obj = longint'(clip_obj(sum));
      end else begin
        // nothing admissible: hand back and drop the oldest tabu key
        res.selection_kind = KIND_FALLBACK;
        if (tl_count > 0) begin
          res.chosen_key = tl_mem[tl_head];
          tl_head  = (tl_head + 1) % DEPTH;
          tl_count = tl_count - 1;
        end
      end
      res.new_best_objective = best_obj[31:0];
      clear_round();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Gap draws per beat, gated by the current idle mode
  // ---------------------------------------------------------------------------
  function automatic int send_gap();
    if (idle_mode == IDLE_BOTH || idle_mode == IDLE_SEND) return $urandom_range(0, 7);
    return 0;
  endfunction

  function automatic int recv_hold();
    if (idle_mode == IDLE_BOTH || idle_mode == IDLE_RECV) return $urandom_range(0, 7);
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] near_best();
    longint off;
    off = longint'($urandom_range(0, 80)) - 40;
    return clip_obj(best_obj + off);
  endfunction

  // tabu keys often, a small per-phase pool next, fresh keys otherwise
  function automatic logic [31:0] pick_key(bit force_tabu);
    int r;
    r = $urandom_range(0, 99);
    if (tl_count > 0 && (force_tabu || r < 40))
      return tl_mem[(tl_head + $urandom_range(0, tl_count - 1)) % DEPTH];
    if (r < 75) return key_pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  // Returns at a falling edge right after acceptance, valid still high:
  // the caller either sends the next beat or drops valid in that same step.
  task automatic send_item(input tms_item_t beat, input bit typed,
                           input tms_result_t want);
    int          gap;
    bit          took;
    bit          closed;
    tms_result_t got;
    gap = send_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= beat;
    item_valid <= 1'b1;
    took = 1'b0;
    while (!took) begin
      @(posedge clk);
      took = (item_stall === 1'b0);
    end
    select_move(beat, closed, got);
    if (closed) pending_choices.insert(pending_choices.size(), typed ? want : got);
    @(negedge clk);
  endtask

  // One round of candidates: mostly well formed, some forced all-tabu,
  // some noise with stray closing flags.
  task automatic run_round(output int sent);
    int                 n;
    int                 style;
    tms_item_t          beat;
    logic signed [31:0] cur;
    n     = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    style = $urandom_range(0, 99);
    if (style < 15 && tl_count == 0) style = 99;
    cur = ($urandom_range(0, 4) == 0) ? $urandom() : near_best();
    if (style < 15) cur = clip_obj(best_obj);  // no aspiration possible
    for (int i = 0; i < n; i++) begin
      beat.last_move = (i == n - 1);
      if (style < 15) begin
        beat.move_key          = pick_key(1'b1);
        beat.move_delta        = $urandom_range(0, 20);
        beat.current_objective = cur;
      end else if (style < 25) begin
        beat.move_key          = pick_key(1'b0);
        beat.move_delta        = $urandom();
        beat.current_objective = $urandom();
        beat.last_move         = (i == n - 1) || ($urandom_range(0, 3) == 0);
      end else begin
        beat.move_key          = pick_key(1'b0);
        beat.move_delta        = ($urandom_range(0, 9) < 7) ?
                                 int'($urandom_range(0, 40)) - 20 : $urandom();
        beat.current_objective = cur;
      end
      send_item(beat, 1'b0, '0);
    end
    sent = n;
  endtask

  // Idle point: drop valid, drain expectations, let the back end finish.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_choices.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_cycle(input bit wr, input logic [PADDR_W-1:0] addr,
                           input logic [31:0] data, output logic [31:0] rdata);
    bit done;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = (pready === 1'b1);
    end
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write, mirror into the shadow, read back
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] readback;
    apb_cycle(1'b1, addr, value, rd);
    if (addr == ADDR_TENURE) begin
      cfg_tenure = value[4:0];
      readback   = {27'd0, value[4:0]};
    end else begin
      cfg_init_best = value;
      best_obj      = longint'($signed(value));  // load also resets best
      readback      = value;
    end
    apb_cycle(1'b0, addr, '0, rd);
    if (rd !== readback) report_mismatch("register readback", rd, readback);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid === 1'b1 && item_stall === 1'b0) ||
          (result_valid === 1'b1 && result_stall === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: random hold before each beat, then take it
  initial begin
    int hold;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = recv_hold();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
      @(negedge clk);
    end
  end

  // checker: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    tms_result_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_choices.size() == 0) begin
        report_mismatch("unexpected result, key", result.chosen_key, '0);
      end else begin
        want = pending_choices.pop_front();
        if (result.chosen_key !== want.chosen_key)
          report_mismatch("chosen_key", result.chosen_key, want.chosen_key);
        if (result.chosen_index !== want.chosen_index)
          report_mismatch("chosen_index", 32'(result.chosen_index), 32'(want.chosen_index));
        if (result.chosen_delta !== want.chosen_delta)
          report_mismatch("chosen_delta", result.chosen_delta, want.chosen_delta);
        if (result.selection_kind !== want.selection_kind)
          report_mismatch("selection_kind", 32'(result.selection_kind),
                          32'(want.selection_kind));
        if (result.new_best_objective !== want.new_best_objective)
          report_mismatch("new_best_objective", result.new_best_objective,
                          want.new_best_objective);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan [$];
    logic [4:0]  ten;
    logic [31:0] init_best;
    int          done_items;
    int          sent;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    idle_mode  = IDLE_BOTH;

    // shadow reset state
    for (int i = 0; i < DEPTH; i++) tl_mem[i] = '0;
    tl_head       = 0;
    tl_count      = 0;
    cfg_tenure    = TENURE_RESET;
    cfg_init_best = INIT_BEST_RESET;
    best_obj      = longint'(INIT_BEST_RESET);
    clear_round();

    // Directed rounds under reset config (tenure 15, best = max).
    // empty list: plain pick, best drops to 0, key 0 goes tabu
    plan.insert(plan.size(), plan_row(32'h0, 32'h0, 32'h0, 1'b1, 1'b1,
                            '{32'h0, 16'd0, 32'h0, KIND_NORMAL, 32'h0}));
    // same key again, beats best: aspiration, not pushed
    plan.insert(plan.size(), plan_row(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1,
                            '{32'h0, 16'd0, 32'hFFFF_FFFF, KIND_ASPIRED, 32'hFFFF_FFFF}));
    // tabu, no aspiration: fallback pops key 0
    plan.insert(plan.size(), plan_row(32'h0, 32'd5, 32'h0, 1'b1, 1'b1,
                            '{32'h0, 16'd0, 32'h0, KIND_FALLBACK, 32'hFFFF_FFFF}));
    // min + min: best saturates at the signed floor
    plan.insert(plan.size(), plan_row(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            1'b1, 1'b1,
                            '{32'hFFFF_FFFF, 16'd0, 32'h8000_0000, KIND_NORMAL,
                              32'h8000_0000}));
    // three-beat round: max delta, tabu reject, lower delta wins at index 2
    plan.insert(plan.size(), plan_row(32'h1234_5678, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'hA5A5_A5A5, 32'd3, 32'h0, 1'b1, 1'b0, '0));
    // all tabu, two entries: oldest comes back
    plan.insert(plan.size(), plan_row(32'hA5A5_A5A5, 32'd0, 32'h0, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'hFFFF_FFFF, 32'd1, 32'h0, 1'b1, 1'b0, '0));
    // tie on delta: first one kept
    plan.insert(plan.size(), plan_row(32'h0000_0001, 32'd4, 32'h0, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'h0000_0002, 32'd4, 32'h0, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'h0000_0003, 32'd7, 32'h0, 1'b1, 1'b0, '0));
    // aspiration below the floor, tied by a plain move: aspired one kept
    plan.insert(plan.size(), plan_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                            1'b0, 1'b0, '0));
    plan.insert(plan.size(), plan_row(32'h0000_0004, 32'hFFFF_FFFF, 32'h8000_0000,
                            1'b1, 1'b0, '0));
    // max fields, best untouched
    plan.insert(plan.size(), plan_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            1'b1, 1'b0, '0));

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].beat, plan[i].typed, plan[i].want);

    // Random phases, each under its own register setting. The early ones
    // hit the extremes; the second one shrinks tenure below the fill.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin ten = 5'd16; init_best = 32'h0000_0000; end
        1: begin ten = 5'd2;  init_best = 32'h7FFF_FFFF; end
        2: begin ten = 5'd0;  init_best = 32'h8000_0000; end
        3: begin ten = 5'd31; init_best = 32'd100; end
        4: begin ten = 5'd1;  init_best = $urandom(); end
        default: begin
          ten = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16));
          init_best = $urandom_range(0, 1) ? $urandom() : int'($urandom_range(0, 2000)) - 1000;
        end
      endcase
      reg_write(ADDR_TENURE, {27'd0, ten});
      if (ph < 5 || $urandom_range(0, 1) == 1) reg_write(ADDR_INIT_BEST, init_best);

      idle_mode = (ph == 0) ? IDLE_BOTH : $urandom_range(0, 3);
      for (int k = 0; k < 6; k++) key_pool[k] = $urandom();
      if (ph % 3 == 0) begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
      end

      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        run_round(sent);
        done_items += sent;
      end
    end

    settle();
    if (pending_choices.size() != 0)
      report_mismatch("results missing", pending_choices.size(), 0);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tms_pkg.sv
rtl/tms_cfg.sv
rtl/tms_front.sv
rtl/tms_back.sv
rtl/tabu_move_selector_core.sv
tb/tabu_move_selector_core_test.sv
